/* rtl/psvm_pkg.sv */
// Shared constants, codes and types of the polyphonic sine voice mixer.
// Used by the controller, the datapath and the top level; depends on nothing.
package psvm_pkg;

    // voice count and sine resolution
    localparam int VOICES          = 128;
    localparam int SINE_TABLE_BITS = 10;
    localparam int VA_W            = (VOICES > 1) ? $clog2(VOICES) : 1;

    // field widths
    localparam int OPC_W     = 2;
    localparam int VOICE_W   = 7;
    localparam int STEP_W    = 32;
    localparam int LEVEL_W   = 16;
    localparam int SAMPLE_W  = 24;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // opcodes of an input transaction
    localparam logic [OPC_W-1:0] OPC_TICK    = 2'd0;
    localparam logic [OPC_W-1:0] OPC_START   = 2'd1;
    localparam logic [OPC_W-1:0] OPC_RELEASE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP = 1'b1;
    localparam logic [CFG_W-1:0]     STEP_RESET       = 16'd655;

    // sine polynomial, Q16 coefficients
    localparam logic [31:0] PHASE_MASK = 32'hFFFF_FFFF << (32 - SINE_TABLE_BITS);
    localparam logic [16:0] SIN_A      = 17'd102944;
    localparam logic [15:0] SIN_B      = 16'd42048;
    localparam logic [12:0] SIN_C      = 13'd4640;

    // mixing accumulator: sample plus VOICES contributions of up to 24 bits
    localparam int CONTRIB_W = 24;
    localparam int ACC_W     = CONTRIB_W + 1 + $clog2(VOICES + 1);

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_ATTACK  = 2'd1,
        MODE_HOLD    = 2'd2,
        MODE_RELEASE = 2'd3
    } voice_mode_t;

    typedef struct packed {
        voice_mode_t          mode;
        logic [STEP_W-1:0]    phase;
        logic [STEP_W-1:0]    step;
        logic [LEVEL_W-1:0]   level;
        logic [LEVEL_W-1:0]   target;
    } voice_rec_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic key_read;
        logic key_write;
        logic sweep_clear;
        logic issue;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OPC_W-1:0] in_opcode;
        logic             in_voice_ok;
        logic             sweep_last;
        logic             pipe_busy;
    } status_t;

endpackage

/* rtl/psvm_if.sv */
// Channel interfaces of the voice mixer: input item channel and result channel.
// Plain valid/ready handshake; depends on nothing.
interface psvm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [6:0]         voice;
    logic [31:0]        phase_step;
    logic [15:0]        target_level;
    logic signed [23:0] buffer_sample;

    modport source (output valid, opcode, voice, phase_step, target_level, buffer_sample,
                    input ready);
    modport sink   (input valid, opcode, voice, phase_step, target_level, buffer_sample,
                    output ready);
endinterface

interface psvm_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] mixed_sample;

    modport source (output valid, mixed_sample, input ready);
    modport sink   (input valid, mixed_sample, output ready);
endinterface

/* rtl/psvm_ctrl.sv */
// Controller of the voice mixer: sequences key updates and the per-tick voice sweep.
// Depends on psvm_pkg; drives the datapath through cmd_t and reads status_t.
module psvm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    output logic               result_valid,
    input  logic               result_ready,
    output psvm_pkg::cmd_t     cmd,
    input  psvm_pkg::status_t  status
);
    import psvm_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_KEY_RD = 5'b00010,
        ST_KEY_WR = 5'b00100,
        ST_SWEEP  = 5'b01000,
        ST_DRAIN  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   item_fire;

    assign item_ready   = (state_reg == ST_IDLE);
    assign item_fire    = item_valid && item_ready;
    assign result_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    cmd.capture = 1'b1;
                    case (status.in_opcode)
                        OPC_TICK:
                        begin
                            cmd.sweep_clear = 1'b1;
                            state_next      = ST_SWEEP;
                        end
                        OPC_START:
                        begin
                            if (status.in_voice_ok)
                            begin
                                state_next = ST_KEY_WR;
                            end
                        end
                        OPC_RELEASE:
                        begin
                            if (status.in_voice_ok)
                            begin
                                state_next = ST_KEY_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_KEY_RD:
            begin
                cmd.key_read = 1'b1;
                state_next   = ST_KEY_WR;
            end
            ST_KEY_WR:
            begin
                cmd.key_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_SWEEP:
            begin
                cmd.issue = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy && (!out_valid_reg || result_ready))
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid flag of the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // new items only enter once the sweep pipeline has drained
    a_ready_drained: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> !status.pipe_busy)
        else $error("item accepted while voice pipeline busy");

    // a finished sum never overwrites a result still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || result_ready))
        else $error("result register overwritten");

    // the sweep stops after the last voice
    a_sweep_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && status.sweep_last) |=> !cmd.issue)
        else $error("sweep ran past the last voice");

    // a loaded sum is presented in the next cycle
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> result_valid)
        else $error("loaded result not presented");

    // key writes never collide with sweep write-back
    a_key_alone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.key_write |-> !status.pipe_busy)
        else $error("key write during voice sweep");

endmodule

/* rtl/psvm_datapath.sv */
// Datapath of the voice mixer: voice memory, config registers, sine/envelope pipeline,
// mixing accumulator and result register. Depends on psvm_pkg; steered by psvm_ctrl.
module psvm_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [psvm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [psvm_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic [psvm_pkg::OPC_W-1:0]          opcode,
    input  logic [psvm_pkg::VOICE_W-1:0]        voice,
    input  logic [psvm_pkg::STEP_W-1:0]         phase_step,
    input  logic [psvm_pkg::LEVEL_W-1:0]        target_level,
    input  logic signed [psvm_pkg::SAMPLE_W-1:0] buffer_sample,
    input  psvm_pkg::cmd_t                      cmd,
    output psvm_pkg::status_t                   status,
    output logic signed [psvm_pkg::SAMPLE_W-1:0] mixed_sample
);
    import psvm_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(8388607);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(8388608);

    // configuration
    logic [CFG_W-1:0]   attack_step_reg;
    logic [CFG_W-1:0]   release_step_reg;

    // captured item
    logic [OPC_W-1:0]   cap_op_reg;
    logic [VA_W-1:0]    cap_voice_reg;
    logic [STEP_W-1:0]  cap_step_reg;
    logic [LEVEL_W-1:0] cap_target_reg;

    // voice memory with per-entry valid bits
    voice_rec_t         voice_mem [VOICES];
    logic [VOICES-1:0]  voice_ok_reg;
    voice_rec_t         rd_rec_reg;
    logic               rd_ok_reg;
    logic               s1_vld_reg;
    logic [VA_W-1:0]    s1_addr_reg;
    logic [VA_W-1:0]    idx_reg;
    logic               mem_re;
    logic [VA_W-1:0]    mem_raddr;
    logic               mem_we;
    logic [VA_W-1:0]    mem_waddr;
    voice_rec_t         mem_wdata;
    logic               key_we;
    voice_rec_t         key_rec;

    // stage a: phase fold, z squared, envelope products
    logic [31:0]        ph;
    logic [15:0]        x;
    logic [16:0]        z_next;
    logic [33:0]        zz_prod;
    logic [31:0]        att_prod;
    logic [31:0]        rel_prod;
    logic               a_act_next;
    voice_rec_t         a_rec_next;
    logic               a_act_reg;
    logic [VA_W-1:0]    a_addr_reg;
    voice_rec_t         a_rec_reg;
    logic               a_neg_reg;
    logic [16:0]        a_z_reg;
    logic [16:0]        a_z2_reg;
    logic [15:0]        a_inc_reg;
    logic [15:0]        a_dec_reg;

    // stage b: envelope step, first polynomial term
    logic [16:0]        nl;
    voice_rec_t         b_rec_next;
    logic [29:0]        c_prod;
    logic               b_act_reg;
    logic [VA_W-1:0]    b_addr_reg;
    voice_rec_t         b_rec_reg;
    logic [15:0]        b_t1_reg;
    logic [16:0]        b_z_reg;
    logic [16:0]        b_z2_reg;
    logic               b_neg_reg;
    logic [15:0]        b_level_reg;

    // stage c to e: rest of the sine and the voice contribution
    logic [32:0]        t2_prod;
    logic               c_act_reg;
    logic [16:0]        c_t3_reg;
    logic [16:0]        c_z_reg;
    logic               c_neg_reg;
    logic [15:0]        c_level_reg;
    logic [33:0]        mag_prod;
    logic               d_act_reg;
    logic [16:0]        d_mag_reg;
    logic               d_neg_reg;
    logic [15:0]        d_level_reg;
    logic [32:0]        out_prod;
    logic               e_act_reg;
    logic [CONTRIB_W-1:0] e_c_reg;
    logic               e_neg_reg;

    // accumulator and result
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [ACC_W-1:0]    contrib;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic signed [SAMPLE_W-1:0] sat_sample;

    // status toward the controller
    assign status.in_opcode   = opcode;
    assign status.in_voice_ok = (32'(voice) < 32'(VOICES));
    assign status.sweep_last  = (idx_reg == VA_W'(VOICES - 1));
    assign status.pipe_busy   = s1_vld_reg | a_act_reg | b_act_reg | c_act_reg
                              | d_act_reg | e_act_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_step_reg  <= STEP_RESET;
            release_step_reg <= STEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ATTACK_STEP:  attack_step_reg  <= cfg_wdata;
                CFG_RELEASE_STEP: release_step_reg <= cfg_wdata;
                default:          attack_step_reg  <= attack_step_reg;
            endcase
        end
    end

    // key update record: start rewrites the voice, release only changes its mode
    always_comb
    begin
        key_rec = rd_rec_reg;
        key_we  = 1'b0;
        if (cap_op_reg == OPC_START)
        begin
            key_rec.mode   = MODE_ATTACK;
            key_rec.phase  = '0;
            key_rec.step   = cap_step_reg;
            key_rec.level  = '0;
            key_rec.target = cap_target_reg;
            key_we         = 1'b1;
        end
        else
        begin
            key_rec.mode = MODE_RELEASE;
            key_we       = rd_ok_reg && ((rd_rec_reg.mode == MODE_ATTACK) ||
                                         (rd_rec_reg.mode == MODE_HOLD));
        end
    end

    // memory port selection
    assign mem_re    = cmd.key_read || cmd.issue;
    assign mem_raddr = cmd.key_read ? cap_voice_reg : idx_reg;
    assign mem_we    = (cmd.key_write && key_we) || b_act_reg;
    assign mem_waddr = b_act_reg ? b_addr_reg : cap_voice_reg;
    assign mem_wdata = b_act_reg ? b_rec_reg : key_rec;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            voice_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_rec_reg <= voice_mem[mem_raddr];
        end
    end

    // stage a datapath
    always_comb
    begin
        ph         = rd_rec_reg.phase & PHASE_MASK;
        x          = ph[29:14];
        z_next     = ph[30] ? (17'd65536 - {1'b0, x}) : {1'b0, x};
        zz_prod    = 34'(z_next) * 34'(z_next);
        att_prod   = 32'(attack_step_reg) * 32'(rd_rec_reg.target);
        rel_prod   = 32'(release_step_reg) * 32'(rd_rec_reg.target);
        a_act_next = s1_vld_reg && rd_ok_reg && (rd_rec_reg.mode != MODE_IDLE);
        a_rec_next       = rd_rec_reg;
        a_rec_next.phase = rd_rec_reg.phase + rd_rec_reg.step;
    end

    // stage b envelope step
    always_comb
    begin
        b_rec_next = a_rec_reg;
        nl         = 17'(a_rec_reg.level) + 17'(a_inc_reg);
        case (a_rec_reg.mode)
            MODE_ATTACK:
            begin
                if (nl >= 17'(a_rec_reg.target))
                begin
                    b_rec_next.level = a_rec_reg.target;
                    b_rec_next.mode  = MODE_HOLD;
                end
                else
                begin
                    b_rec_next.level = nl[15:0];
                end
            end
            MODE_RELEASE:
            begin
                if (a_rec_reg.level <= a_dec_reg)
                begin
                    b_rec_next.level = '0;
                    b_rec_next.mode  = MODE_IDLE;
                end
                else
                begin
                    b_rec_next.level = a_rec_reg.level - a_dec_reg;
                end
            end
            default:
            begin
                b_rec_next = a_rec_reg;
            end
        endcase
        c_prod = 30'(SIN_C) * 30'(a_z2_reg);
    end

    // later stage products
    assign t2_prod  = 33'(b_t1_reg) * 33'(b_z2_reg);
    assign mag_prod = 34'(c_t3_reg) * 34'(c_z_reg);
    assign out_prod = 33'(d_mag_reg) * 33'(d_level_reg);

    // accumulate the signed contribution
    assign contrib = ACC_W'(e_c_reg);
    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.capture)
        begin
            acc_next = ACC_W'(buffer_sample);
        end
        else if (e_act_reg)
        begin
            acc_next = e_neg_reg ? (acc_reg - contrib) : (acc_reg + contrib);
        end
    end

    // saturate to the sample range
    always_comb
    begin
        if (acc_reg > SAT_MAX)
        begin
            sat_sample = SAMPLE_W'(SAT_MAX);
        end
        else if (acc_reg < SAT_MIN)
        begin
            sat_sample = SAMPLE_W'(SAT_MIN);
        end
        else
        begin
            sat_sample = acc_reg[SAMPLE_W-1:0];
        end
    end

    assign mixed_sample = out_sample_reg;

    // control flags: valid bits, sweep index, pipeline occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_ok_reg <= '0;
            rd_ok_reg    <= 1'b0;
            idx_reg      <= '0;
            s1_vld_reg   <= 1'b0;
            a_act_reg    <= 1'b0;
            b_act_reg    <= 1'b0;
            c_act_reg    <= 1'b0;
            d_act_reg    <= 1'b0;
            e_act_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.key_write && (cap_op_reg == OPC_START))
            begin
                voice_ok_reg[cap_voice_reg] <= 1'b1;
            end
            if (mem_re)
            begin
                rd_ok_reg <= voice_ok_reg[mem_raddr];
            end
            if (cmd.sweep_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            s1_vld_reg <= cmd.issue;
            a_act_reg  <= a_act_next;
            b_act_reg  <= a_act_reg;
            c_act_reg  <= b_act_reg;
            d_act_reg  <= c_act_reg;
            e_act_reg  <= d_act_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cap_op_reg     <= opcode;
            cap_voice_reg  <= VA_W'(voice);
            cap_step_reg   <= phase_step;
            cap_target_reg <= target_level;
        end
        acc_reg <= acc_next;
        if (cmd.load_out)
        begin
            out_sample_reg <= sat_sample;
        end

        s1_addr_reg <= idx_reg;

        a_addr_reg <= s1_addr_reg;
        a_rec_reg  <= a_rec_next;
        a_neg_reg  <= ph[31];
        a_z_reg    <= z_next;
        a_z2_reg   <= zz_prod[32:16];
        a_inc_reg  <= att_prod[31:16];
        a_dec_reg  <= rel_prod[31:16];

        b_addr_reg  <= a_addr_reg;
        b_rec_reg   <= b_rec_next;
        b_t1_reg    <= SIN_B - 16'(c_prod[29:16]);
        b_z_reg     <= a_z_reg;
        b_z2_reg    <= a_z2_reg;
        b_neg_reg   <= a_neg_reg;
        b_level_reg <= a_rec_reg.level;

        c_t3_reg    <= SIN_A - t2_prod[32:16];
        c_z_reg     <= b_z_reg;
        c_neg_reg   <= b_neg_reg;
        c_level_reg <= b_level_reg;

        d_mag_reg   <= mag_prod[32:16];
        d_neg_reg   <= c_neg_reg;
        d_level_reg <= c_level_reg;

        e_c_reg   <= out_prod[32:9];
        e_neg_reg <= d_neg_reg;
    end

endmodule

/* rtl/poly_sine_voice_mixer.sv */
// Top level of the polyphonic sine voice mixer: controller plus datapath.
// Depends on psvm_pkg, psvm_in_if/psvm_out_if, psvm_ctrl and psvm_datapath.
//
//  channel    role    payload
//  item_ch    sink    opcode, voice, phase_step, target_level, buffer_sample
//  result_ch  source  mixed_sample (one per tick)
//  cfg_*      write   cfg_index 0 attack_step, 1 release_step
//
// During a tick the voice memory's single read port visits one voice per cycle,
// then the sine/envelope pipeline (memory read, stages a to e) drains.
// A key start captures then writes; a release captures, reads, writes the mode.
// No clearing pass after reset: per-voice valid bits mark voices never started.
// A result waits in the output register while new transactions are taken; a tick
// that finishes while the previous result is still unread holds until it is read.
module poly_sine_voice_mixer (
    input  logic                              clk,
    input  logic                              rst_n,
    psvm_in_if.sink                           item_ch,
    psvm_out_if.source                        result_ch,
    input  logic                              cfg_wr_en,
    input  logic [psvm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psvm_pkg::CFG_W-1:0]        cfg_wdata
);
    import psvm_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencing
    psvm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_ch.valid),
        .item_ready   (item_ch.ready),
        .result_valid (result_ch.valid),
        .result_ready (result_ch.ready),
        .cmd          (cmd),
        .status       (status)
    );

    // voice storage and arithmetic
    psvm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .opcode        (item_ch.opcode),
        .voice         (item_ch.voice),
        .phase_step    (item_ch.phase_step),
        .target_level  (item_ch.target_level),
        .buffer_sample (item_ch.buffer_sample),
        .cmd           (cmd),
        .status        (status),
        .mixed_sample  (result_ch.mixed_sample)
    );

endmodule
